// ===== rtl/plpt_pkg.sv =====
// Shared types and constants of the piecewise-linear profile table.
package plpt_pkg;

  // One stored breakpoint
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] vel;
    logic [31:0] den;
  } entry_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MASS  = 2'd0;
  localparam logic [1:0] CFG_BOLTZ = 2'd1;

  // Item actions
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // Saturation limit of the energy and temperature results
  localparam logic [30:0] SAT_MAX = 31'h7fff_ffff;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // latch the accepted item and clear the result
    logic set_drop;  // flag a refused insert
    logic ptr_cnt;   // pointer to entry count
    logic ptr_zero;  // pointer to zero
    logic ptr_dec;
    logic ptr_inc;
    logic rd_prev;   // read entry below the pointer
    logic rd_cur;    // read entry at the pointer
    logic wr_shift;  // move the read entry up to the pointer
    logic wr_new;    // write the new entry at the pointer, count it
    logic prev_load; // keep the read entry as lower bound
    logic seg_load;  // interval found: latch bounds, start fraction division
    logic mul_v;
    logic mul_d;
    logic mul_sq;
    logic e_lo;
    logic e_hi;
    logic e_sum;     // finish energy, start temperature division if needed
    logic t_load;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic few;       // fewer than two entries
    logic ptr_zero;
    logic ptr_one;
    logic ptr_last;
    logic key_gt;
    logic in_seg;
    logic div_done;
    logic t_div;
  } status_t;

endpackage

// ===== rtl/plpt_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
module plpt_div #(
  parameter int DW = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [32:0]   divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_q, quo_d;
  logic [33:0]   rem_q, rem_d;
  logic [32:0]   dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [33:0]   trial;
  logic          ge;

  // One restoring step
  always_comb begin
    trial = {rem_q[32:0], quo_q[DW-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? (trial - {1'b0, dvs_q}) : trial;
    quo_d = {quo_q[DW-2:0], ge};
  end

  // Control: run for DW steps, pulse done at the end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q != CW'(1) |-> !start_i)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/plpt_dp.sv =====
// Datapath: breakpoint memory, pointers, multiplier, divider and result registers.
module plpt_dp #(
  parameter int ENTRIES   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plpt_pkg::cmd_t      cmd_i,
  output plpt_pkg::status_t   status_o,
  input  logic [31:0]         position_i,
  input  logic [31:0]         velocity_in_i,
  input  logic [31:0]         density_in_i,
  input  logic                cfg_valid_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output logic [31:0]         velocity_out_o,
  output logic [31:0]         density_out_o,
  output logic [31:0]         energy_out_o,
  output logic [31:0]         temperature_out_o,
  output logic                in_range_o,
  output logic                insert_dropped_o
);

  localparam int AW   = $clog2(ENTRIES);
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int DW   = 32 + FRAC_BITS;
  localparam int WW   = 64 - FRAC_BITS;
  localparam int WHW  = WW - 32;
  localparam int PW   = 31 + WW + 1;

  plpt_pkg::entry_t mem_q [ENTRIES];
  plpt_pkg::entry_t rd_q, prev_q, lo_q, hi_q, wr_data;

  logic [31:0]     x_q, vin_q, din_q;
  logic [CNTW-1:0] count_q, ptr_q, ptr_m1;
  logic [AW-1:0]   rd_addr;
  logic            rd_en, wr_en;
  logic [30:0]     mass_q, bs_q;

  logic signed [67:0] mul_q, mul_p, mul_sh;
  logic signed [33:0] mul_a, mul_b;
  logic [WHW-1:0]     w_hi_q;
  logic [WW-1:0]      w;
  logic [63:0]        acc_q;
  logic [PW-1:0]      esum;
  logic [30:0]        e_val;
  logic [33:0]        mag, lerp_v, lerp_d;
  logic [FRAC_BITS:0] delta;

  logic [31:0] vel_q, den_q, energy_q, temp_q;
  logic        hit_q, drop_q;

  logic          div_start, div_done;
  logic [DW-1:0] div_dividend, div_quot;
  logic [32:0]   div_divisor;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q <= 31'(1) << FRAC_BITS;
      bs_q   <= 31'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == plpt_pkg::CFG_MASS) begin
        mass_q <= cfg_data_i[30:0];
      end else if (cfg_index_i == plpt_pkg::CFG_BOLTZ) begin
        bs_q <= cfg_data_i[30:0];
      end
    end
  end

  // Entry count and walk pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (cmd_i.wr_new) begin
        count_q <= count_q + CNTW'(1);
      end
      if (cmd_i.ptr_cnt) begin
        ptr_q <= count_q;
      end else if (cmd_i.ptr_zero) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_m1;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + CNTW'(1);
      end
    end
  end

  assign ptr_m1  = ptr_q - CNTW'(1);
  assign rd_addr = cmd_i.rd_prev ? ptr_m1[AW-1:0] : ptr_q[AW-1:0];
  assign rd_en   = cmd_i.rd_prev | cmd_i.rd_cur;
  assign wr_en   = cmd_i.wr_shift | cmd_i.wr_new;
  assign wr_data = cmd_i.wr_shift ? rd_q : {x_q, vin_q, din_q};

  // Breakpoint memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[ptr_q[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // Shared multiplier operands
  assign delta = div_quot[FRAC_BITS:0];
  assign mag   = vel_q[31] ? (34'd0 - {{2{vel_q[31]}}, vel_q}) : {2'b00, vel_q};
  assign w     = mul_q[63:FRAC_BITS];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.mul_v) begin
      mul_a = $signed({{2{hi_q.vel[31]}}, hi_q.vel}) - $signed({{2{lo_q.vel[31]}}, lo_q.vel});
      mul_b = $signed({(33 - FRAC_BITS)'(0), delta});
    end else if (cmd_i.mul_d) begin
      mul_a = $signed({{2{hi_q.den[31]}}, hi_q.den}) - $signed({{2{lo_q.den[31]}}, lo_q.den});
      mul_b = $signed({(33 - FRAC_BITS)'(0), delta});
    end else if (cmd_i.mul_sq) begin
      mul_a = $signed(mag);
      mul_b = $signed(mag);
    end else if (cmd_i.e_lo) begin
      mul_a = $signed({3'b000, mass_q});
      mul_b = $signed({2'b00, w[31:0]});
    end else if (cmd_i.e_hi) begin
      mul_a = $signed({3'b000, mass_q});
      mul_b = $signed({(34 - WHW)'(0), w_hi_q});
    end
  end

  assign mul_p  = mul_a * mul_b;
  assign mul_sh = mul_q >>> FRAC_BITS;
  assign lerp_v = {{2{lo_q.vel[31]}}, lo_q.vel} + mul_sh[33:0];
  assign lerp_d = {{2{lo_q.den[31]}}, lo_q.den} + mul_sh[33:0];

  // Energy: sum the partial products, saturate
  assign esum  = PW'(acc_q) + (PW'(mul_q[63:0]) << 32);
  assign e_val = (|esum[PW-1:FRAC_BITS+32]) ? plpt_pkg::SAT_MAX
                                            : esum[FRAC_BITS+31:FRAC_BITS+1];

  // Divider operands: interval fraction or temperature
  assign div_start = cmd_i.seg_load | (cmd_i.e_sum & status_o.t_div);
  always_comb begin
    if (cmd_i.seg_load) begin
      div_dividend = {x_q - prev_q.key, FRAC_BITS'(0)};
      div_divisor  = {1'b0, rd_q.key - prev_q.key};
    end else begin
      div_dividend = {1'b0, e_val, FRAC_BITS'(0)};
      div_divisor  = 33'(bs_q) + {1'b0, bs_q, 1'b0};
    end
  end

  plpt_div #(.DW(DW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // Working registers of the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q      <= position_i;
      vin_q    <= velocity_in_i;
      din_q    <= density_in_i;
      vel_q    <= '0;
      den_q    <= '0;
      energy_q <= '0;
      temp_q   <= '0;
      hit_q    <= 1'b0;
      drop_q   <= cmd_i.set_drop;
    end
    if (cmd_i.prev_load) begin
      prev_q <= rd_q;
    end
    if (cmd_i.seg_load) begin
      lo_q  <= prev_q;
      hi_q  <= rd_q;
      hit_q <= 1'b1;
    end
    if (cmd_i.mul_v | cmd_i.mul_d | cmd_i.mul_sq | cmd_i.e_lo | cmd_i.e_hi) begin
      mul_q <= mul_p;
    end
    if (cmd_i.mul_d) begin
      vel_q <= lerp_v[31:0];
    end
    if (cmd_i.mul_sq) begin
      den_q <= lerp_d[31:0];
    end
    if (cmd_i.e_lo) begin
      w_hi_q <= w[WW-1:32];
    end
    if (cmd_i.e_hi) begin
      acc_q <= mul_q[63:0];
    end
    if (cmd_i.e_sum) begin
      energy_q <= {1'b0, e_val};
      if (e_val != '0 && bs_q == '0) begin
        temp_q <= {1'b0, plpt_pkg::SAT_MAX};
      end
    end
    if (cmd_i.t_load) begin
      temp_q <= (|div_quot[DW-1:31]) ? {1'b0, plpt_pkg::SAT_MAX} : {1'b0, div_quot[30:0]};
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      velocity_out_o    <= vel_q;
      density_out_o     <= den_q;
      energy_out_o      <= energy_q;
      temperature_out_o <= temp_q;
      in_range_o        <= hit_q;
      insert_dropped_o  <= drop_q;
    end
  end

  // Status
  assign status_o.full     = count_q == CNTW'(ENTRIES);
  assign status_o.empty    = count_q == '0;
  assign status_o.few      = count_q < CNTW'(2);
  assign status_o.ptr_zero = ptr_q == '0;
  assign status_o.ptr_one  = ptr_q == CNTW'(1);
  assign status_o.ptr_last = (ptr_q + CNTW'(1)) == count_q;
  assign status_o.key_gt   = $signed(rd_q.key) > $signed(x_q);
  assign status_o.in_seg   = ($signed(prev_q.key) < $signed(x_q))
                           && ($signed(x_q) <= $signed(rd_q.key));
  assign status_o.div_done = div_done;
  assign status_o.t_div    = (e_val != '0) && (bs_q != '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(ENTRIES))
    else $error("entry count beyond table size");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> !status_o.full)
    else $error("insert written into a full table");

  a_seg_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.seg_load |-> !status_o.few && !status_o.ptr_zero)
    else $error("interval found with fewer than two entries");

endmodule

// ===== rtl/plpt_ctrl.sv =====
// Controller: sequences insert walks, query search and the arithmetic steps.
module plpt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              action_i,
  output logic              in_stall_o,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  input  plpt_pkg::status_t status_i,
  output plpt_pkg::cmd_t    cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_INS_RD  = 15'h0002,
    S_INS_CMP = 15'h0004,
    S_INS_WR  = 15'h0008,
    S_Q_RD    = 15'h0010,
    S_Q_CMP   = 15'h0020,
    S_DIV_D   = 15'h0040,
    S_MUL_V   = 15'h0080,
    S_MUL_D   = 15'h0100,
    S_SQ      = 15'h0200,
    S_E_LO    = 15'h0400,
    S_E_HI    = 15'h0800,
    S_E_SUM   = 15'h1000,
    S_DIV_T   = 15'h2000,
    S_DONE    = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = state_q != S_IDLE;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          if (action_i == plpt_pkg::ACT_INSERT) begin
            if (status_i.full) begin
              cmd_o.set_drop = 1'b1;
              state_d        = S_DONE;
            end else begin
              cmd_o.ptr_cnt = 1'b1;
              state_d       = status_i.empty ? S_INS_WR : S_INS_RD;
            end
          end else if (status_i.few) begin
            state_d = S_DONE;
          end else begin
            cmd_o.ptr_zero = 1'b1;
            state_d        = S_Q_RD;
          end
        end
      end
      S_INS_RD: begin
        cmd_o.rd_prev = 1'b1;
        state_d       = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (status_i.key_gt) begin
          cmd_o.wr_shift = 1'b1;
          cmd_o.ptr_dec  = 1'b1;
          state_d        = status_i.ptr_one ? S_INS_WR : S_INS_RD;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_new = 1'b1;
        state_d      = S_DONE;
      end
      S_Q_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (!status_i.ptr_zero && status_i.in_seg) begin
          cmd_o.seg_load = 1'b1;
          state_d        = S_DIV_D;
        end else begin
          cmd_o.prev_load = 1'b1;
          cmd_o.ptr_inc   = 1'b1;
          state_d         = status_i.ptr_last ? S_DONE : S_Q_RD;
        end
      end
      S_DIV_D: begin
        if (status_i.div_done) begin
          state_d = S_MUL_V;
        end
      end
      S_MUL_V: begin
        cmd_o.mul_v = 1'b1;
        state_d     = S_MUL_D;
      end
      S_MUL_D: begin
        cmd_o.mul_d = 1'b1;
        state_d     = S_SQ;
      end
      S_SQ: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = S_E_LO;
      end
      S_E_LO: begin
        cmd_o.e_lo = 1'b1;
        state_d    = S_E_HI;
      end
      S_E_HI: begin
        cmd_o.e_hi = 1'b1;
        state_d    = S_E_SUM;
      end
      S_E_SUM: begin
        cmd_o.e_sum = 1'b1;
        state_d     = status_i.t_div ? S_DIV_T : S_DONE;
      end
      S_DIV_T: begin
        if (status_i.div_done) begin
          cmd_o.t_load = 1'b1;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop after transfer
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/piecewise_linear_profile_table.sv =====
// Top level of the piecewise-linear profile table.
//
// Input channel (in_valid_i / in_stall_o) carries one item: action_i selects
// an insert of a breakpoint (position, velocity, density) or a query at
// position_i. Every item gives exactly one result on the output channel
// (out_valid_o / out_stall_i). Writes on the configuration channel
// (cfg_valid_i / cfg_ready_o, always ready) set particle mass (index 0) and
// the Boltzmann scale (index 1); write them only while the block is idle.
// One item is worked at a time. An insert walks down from the top of the table,
// moving each stored entry with a larger key up one place, then writes the new
// entry; a full table drops it and flags the drop. A query walks up from the
// bottom to the interval that holds position_i; if it finds one it runs a
// fraction division, the multiply and energy steps and, if needed, a temperature
// division. With fewer than two entries there is no walk. Insert and query time
// rests on the walk over the entry memory and on the bit-serial divider. A finished
// result waits in the output register while the receiver stalls; the next item
// is taken meanwhile and holds in its last step until the register frees. Reset
// empties the table and restores mass and scale to 1.0; stored entries need no
// clearing.
module piecewise_linear_profile_table #(
  parameter int ENTRIES   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] position_i,
  input  logic [31:0] velocity_in_i,
  input  logic [31:0] density_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] velocity_out_o,
  output logic [31:0] density_out_o,
  output logic [31:0] energy_out_o,
  output logic [31:0] temperature_out_o,
  output logic        in_range_o,
  output logic        insert_dropped_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  plpt_pkg::cmd_t    cmd;
  plpt_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  plpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (action_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  plpt_dp #(
    .ENTRIES   (ENTRIES),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .position_i        (position_i),
    .velocity_in_i     (velocity_in_i),
    .density_in_i      (density_in_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .velocity_out_o    (velocity_out_o),
    .density_out_o     (density_out_o),
    .energy_out_o      (energy_out_o),
    .temperature_out_o (temperature_out_o),
    .in_range_o        (in_range_o),
    .insert_dropped_o  (insert_dropped_o)
  );

endmodule
